/* rtl/des_ks_pkg.sv */
// DES key schedule package: widths, permutation tables and helper functions.
// No dependencies; used by every module of the key schedule.
package des_ks_pkg;

    localparam int KEY_BITS    = 64;
    localparam int HALF_BITS   = 28;
    localparam int CD_BITS     = 2 * HALF_BITS;
    localparam int SUBKEY_BITS = 48;
    localparam int ROUNDS      = 16;
    localparam int ROUND_BITS  = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [HALF_BITS-1:0]   half_t;
    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [SUBKEY_BITS-1:0] subkey_t;
    typedef logic [ROUND_BITS-1:0]  round_t;

    typedef struct packed {
        half_t c;
        half_t d;
    } halves_t;

    localparam logic [7:0] PC1_TABLE [CD_BITS] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam logic [7:0] PC2_TABLE [SUBKEY_BITS] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
        8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
        8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
        8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
        8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
        8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
        8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // bit r set: round r rotates by two places, else by one
    localparam logic [ROUNDS-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

    // DES bit n (1-based, MSB first) lives at key bit 64-n
    function automatic halves_t pc1(input key_t key);
        logic [CD_BITS-1:0] cd;
        cd = '0;
        for (int i = 0; i < CD_BITS; i++)
        begin
            cd[CD_BITS-1-i] = key[KEY_BITS - int'(PC1_TABLE[i])];
        end
        return halves_t'(cd);
    endfunction

    function automatic subkey_t pc2(input halves_t cd);
        subkey_t sub;
        logic [CD_BITS-1:0] joined;
        joined = cd;
        sub = '0;
        for (int i = 0; i < SUBKEY_BITS; i++)
        begin
            sub[SUBKEY_BITS-1-i] = joined[CD_BITS - int'(PC2_TABLE[i])];
        end
        return sub;
    endfunction

endpackage

/* rtl/des_ks_if.sv */
// Handshake channels of the key schedule: key input and subkey output.
// Depends on des_ks_pkg for payload types.
interface des_ks_key_if;
    logic              valid;
    logic              ready;
    des_ks_pkg::key_t  key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

interface des_ks_sub_if;
    logic                 valid;
    logic                 ready;
    des_ks_pkg::subkey_t  subkey;
    des_ks_pkg::round_t   round;
    logic                 last;

    modport source (output valid, output subkey, output round, output last, input ready);
    modport sink   (input valid, input subkey, input round, input last, output ready);
endinterface

/* rtl/des_ks_front.sv */
// Front end: accepts a key, applies PC-1 and registers the C/D halves
// for the queue. Depends on des_ks_pkg and des_ks_if.
module des_ks_front (
    input  logic                  clk,
    input  logic                  rst_n,
    des_ks_key_if.sink            keys,
    output logic                  push_valid,
    output des_ks_pkg::halves_t   push_data,
    input  logic                  push_ready
);

    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    des_ks_pkg::halves_t  stage_reg;

    assign keys.ready = !stage_valid_reg || push_ready;
    assign push_valid = stage_valid_reg;
    assign push_data  = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (keys.valid && keys.ready)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            stage_reg <= des_ks_pkg::pc1(keys.key);
        end
    end

endmodule

/* rtl/des_ks_queue.sv */
// Short FIFO of C/D halves between front end and round engine.
// Depends on des_ks_pkg.
module des_ks_queue #(
    parameter int DEPTH = des_ks_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  des_ks_pkg::halves_t   push_data,
    output logic                  push_ready,
    output logic                  pop_valid,
    output des_ks_pkg::halves_t   pop_data,
    input  logic                  pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    des_ks_pkg::halves_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/des_ks_rounds.sv */
// Round engine: rotates C/D per the shift schedule, applies PC-2 and registers
// one subkey per cycle while not stalled. Depends on des_ks_pkg and des_ks_if.
module des_ks_rounds (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  des_ks_pkg::halves_t   pop_data,
    output logic                  pop_ready,
    des_ks_sub_if.source          subkeys
);

    localparam des_ks_pkg::round_t FINAL_ROUND =
        des_ks_pkg::ROUND_BITS'(des_ks_pkg::ROUNDS - 1);

    des_ks_pkg::halves_t  cd_reg;
    des_ks_pkg::halves_t  cd_rot;
    des_ks_pkg::round_t   rnd_reg;
    des_ks_pkg::round_t   rnd_next;
    logic                 active_reg;
    logic                 active_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    des_ks_pkg::subkey_t  out_subkey_reg;
    des_ks_pkg::round_t   out_round_reg;
    logic                 out_last_reg;
    logic                 step;
    logic                 is_final;
    logic                 load;

    assign step      = active_reg && (!out_valid_reg || subkeys.ready);
    assign is_final  = rnd_reg == FINAL_ROUND;
    // a new key enters when the engine is free or its final round goes out now
    assign pop_ready = !active_reg || (step && is_final);
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        if (des_ks_pkg::ROT_TWO[rnd_reg])
        begin
            cd_rot.c = {cd_reg.c[des_ks_pkg::HALF_BITS-3:0],
                        cd_reg.c[des_ks_pkg::HALF_BITS-1 -: 2]};
            cd_rot.d = {cd_reg.d[des_ks_pkg::HALF_BITS-3:0],
                        cd_reg.d[des_ks_pkg::HALF_BITS-1 -: 2]};
        end
        else
        begin
            cd_rot.c = {cd_reg.c[des_ks_pkg::HALF_BITS-2:0],
                        cd_reg.c[des_ks_pkg::HALF_BITS-1]};
            cd_rot.d = {cd_reg.d[des_ks_pkg::HALF_BITS-2:0],
                        cd_reg.d[des_ks_pkg::HALF_BITS-1]};
        end
    end

    always_comb
    begin
        rnd_next       = rnd_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (subkeys.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step)
        begin
            out_valid_next = 1'b1;
            rnd_next       = rnd_reg + des_ks_pkg::ROUND_BITS'(1);
            if (is_final)
            begin
                active_next = 1'b0;
            end
        end
        if (load)
        begin
            rnd_next    = '0;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rnd_reg       <= rnd_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cd_reg <= pop_data;
        end
        else if (step)
        begin
            cd_reg <= cd_rot;
        end
        if (step)
        begin
            out_subkey_reg <= des_ks_pkg::pc2(cd_rot);
            out_round_reg  <= rnd_reg;
            out_last_reg   <= is_final;
        end
    end

    assign subkeys.valid  = out_valid_reg;
    assign subkeys.subkey = out_subkey_reg;
    assign subkeys.round  = out_round_reg;
    assign subkeys.last   = out_last_reg;

endmodule

/* rtl/des_ks_key_schedule.sv */
// A key passes the front-end register, queue, C/D register and subkey output register.
// One subkey per cycle unless the output stalls, from the single round engine.
// Up to QUEUE_DEPTH + 1 keys are buffered ahead of the engine, so keys run back to back.
// Reset (rst_n, async, active low) empties the queue and stops the engine;
// no clearing pass, the block takes keys in the first cycle after reset.
module des_key_schedule #(
    parameter int QUEUE_DEPTH = des_ks_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    des_ks_key_if.sink    keys,
    des_ks_sub_if.source  subkeys
);

    logic                 push_valid;
    logic                 push_ready;
    des_ks_pkg::halves_t  push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    des_ks_pkg::halves_t  pop_data;

    des_ks_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .keys       (keys),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    des_ks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    des_ks_rounds u_rounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .subkeys   (subkeys)
    );

endmodule
